// ===== hw/rtl/lgps_pkg.sv =====
// Shared types, constants and the preset gait table for the gait phase scheduler.
// Used by every module under hw/rtl; depends on nothing.
package lgps_pkg;

    localparam int FEET_DEF = 4;

    localparam int NUM_W = 52;
    localparam int DEN_W = 27;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] N_TR = 6'd52;
    localparam logic [CNT_W-1:0] N_DPH = 6'd45;
    localparam logic [CNT_W-1:0] N_FOOT = 6'd40;

    localparam logic [24:0] ONE24 = 25'd16777216;
    localparam logic [26:0] MASK27 = 27'd134217727;
    localparam logic [26:0] STAND_PERIOD = 27'd10485760;
    localparam logic [26:0] DISABLED_PERIOD = 27'd104857600;
    localparam logic [26:0] PERIOD_TOL = 27'd105;
    localparam logic [24:0] SWITCH_TOL = 25'd1678;
    localparam logic [23:0] HALF24 = 24'd8388608;
    localparam logic [16:0] SUB_ONE = 17'd65536;

    localparam logic [3:0] GAIT_STAND = 4'd0;
    localparam logic [3:0] GAIT_CUSTOM = 4'd14;
    localparam logic [3:0] GAIT_TRANSITION = 4'd15;

    localparam logic [2:0] MODE_FOLLOW = 3'd0;
    localparam logic [2:0] MODE_CHOICE = 3'd1;
    localparam logic [2:0] MODE_OVERRIDE = 3'd2;
    localparam logic [2:0] MODE_FOLLOW_ALT = 3'd3;
    localparam logic [2:0] MODE_NATURAL = 3'd4;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_CHOICE = 3'd1;
    localparam logic [2:0] REG_PERIOD = 3'd2;
    localparam logic [2:0] REG_SWITCH = 3'd3;
    localparam logic [2:0] REG_TICK = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MODE,
        S_TR_MUL,
        S_TR_DIV,
        S_TR_WAIT,
        S_TR_END,
        S_POST,
        S_DPH,
        S_DPH_WAIT,
        S_FOOT_MUL,
        S_FOOT_DIV,
        S_FOOT_WAIT,
        S_FOOT_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_TR,
        DIV_DPH,
        DIV_FOOT
    } t_div_sel;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  choice;
        logic [26:0] period;
        logic [24:0] switching;
        logic [20:0] tick;
    } t_cfg;

    typedef struct packed {
        logic     load_req;
        logic     mode_step;
        logic     tr_mul;
        logic     tr_store;
        logic     tr_end;
        logic     post;
        logic     dph_store;
        logic     foot_prep;
        logic     foot_store;
        logic     div_start;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic tr_needed;
        logic tr_skip;
        logic dph_skip;
        logic foot_skip;
        logic div_done;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [26:0]      period;
        logic [23:0]      init;
        logic [24:0]      sw;
        logic             ovr;
        logic [3:0]       en;
        logic [3:0][23:0] off;
    } t_preset;

    function automatic t_preset lgps_preset(input logic [3:0] code);
        t_preset p;
        p.init = 24'd0;
        p.en = 4'b1111;
        p.ovr = 1'b1;
        case (code)
            4'd1: begin
                p.period = 27'd1048576; p.sw = 25'd16777216; p.ovr = 1'b0;
                p.off = {HALF24, HALF24, HALF24, HALF24};
            end
            4'd2: begin
                p.period = 27'd1310720; p.sw = 25'd13421773;
                p.off = {24'd8388608, 24'd12582912, 24'd0, 24'd4194304};
            end
            4'd3: begin
                p.period = 27'd524288; p.sw = 25'd10485760;
                p.off = {24'd12582912, 24'd4194304, 24'd8388608, 24'd0};
            end
            4'd4: begin
                p.period = 27'd524288; p.sw = 25'd10066330;
                p.off = {24'd0, HALF24, HALF24, 24'd0};
            end
            4'd5: begin
                p.period = 27'd524288; p.sw = 25'd8388608;
                p.off = {24'd0, HALF24, HALF24, 24'd0};
            end
            4'd6: begin
                p.period = 27'd419430; p.sw = 25'd6710886;
                p.off = {24'd0, HALF24, HALF24, 24'd0};
            end
            4'd7: begin
                p.period = 27'd367002; p.sw = 25'd8388608; p.init = 24'd4194304;
                p.off = {HALF24, 24'd0, HALF24, 24'd0};
            end
            4'd8: begin
                p.period = 27'd419430; p.sw = 25'd6710886;
                p.off = {HALF24, HALF24, 24'd0, 24'd0};
            end
            4'd9: begin
                p.period = 27'd419430; p.sw = 25'd3355443;
                p.off = {24'd8388608, 24'd5991144, 24'd14379752, 24'd0};
            end
            4'd10: begin
                p.period = 27'd524288; p.sw = 25'd3355443;
                p.off = {24'd8388608, 24'd5991144, 24'd14379752, 24'd0};
            end
            4'd11: begin
                p.period = 27'd524288; p.sw = 25'd8388608;
                p.off = {24'd0, 24'd0, 24'd0, 24'd0};
            end
            4'd12: begin
                p.period = 27'd419430; p.sw = 25'd11173626; p.en = 4'b1110;
                p.off = {24'd5586813, 24'd0, 24'd11173626, 24'd0};
            end
            4'd13: begin
                p.period = 27'd419430; p.sw = 25'd11173626; p.en = 4'b1001;
                p.off = {HALF24, 24'd0, 24'd0, 24'd0};
            end
            default: begin
                p.period = STAND_PERIOD; p.sw = ONE24; p.ovr = 1'b0;
                p.off = {HALF24, HALF24, HALF24, HALF24};
            end
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/lgps_regs.sv =====
// Configuration register file with APB-style write and read access.
// Depends on lgps_pkg for register indexes and the configuration struct.
module lgps_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output lgps_pkg::t_cfg  o_cfg
);
    import lgps_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_FOLLOW;
            r_cfg.choice <= GAIT_STAND;
            r_cfg.period <= 27'd524288;
            r_cfg.switching <= 25'd8388608;
            r_cfg.tick <= 21'd2097;
        end else if (wr) begin
            unique case (paddr[4:2])
                REG_MODE:   r_cfg.mode <= pwdata[2:0];
                REG_CHOICE: r_cfg.choice <= pwdata[3:0];
                REG_PERIOD: r_cfg.period <= pwdata[26:0];
                REG_SWITCH: r_cfg.switching <= pwdata[24:0];
                REG_TICK:   r_cfg.tick <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_MODE:   prdata = {29'd0, r_cfg.mode};
            REG_CHOICE: prdata = {28'd0, r_cfg.choice};
            REG_PERIOD: prdata = {5'd0, r_cfg.period};
            REG_SWITCH: prdata = {7'd0, r_cfg.switching};
            REG_TICK:   prdata = {11'd0, r_cfg.tick};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/lgps_div.sv =====
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
// Depends on lgps_pkg for operand widths.
module lgps_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lgps_pkg::NUM_W-1:0]     i_num,
    input  logic [lgps_pkg::DEN_W-1:0]     i_den,
    input  logic [lgps_pkg::CNT_W-1:0]     i_bits,
    output logic                           o_done,
    output logic [lgps_pkg::NUM_W-1:0]     o_quot
);
    import lgps_pkg::*;

    logic [NUM_W-1:0] r_num, r_quot;
    logic [DEN_W-1:0] r_den, r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge = trial >= {1'b0, r_den};
    assign diff = trial - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= i_bits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

endmodule

// ===== hw/rtl/lgps_datapath.sv =====
// Gait state, per-foot phase lanes, shared multiplier and divider, output register.
// Depends on lgps_pkg and lgps_div; sequenced by lgps_ctrl through t_cmd and t_sts.
module lgps_datapath #(
    parameter int FEET = lgps_pkg::FEET_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lgps_pkg::t_cfg              i_cfg,
    input  lgps_pkg::t_cmd              i_cmd,
    input  logic [$clog2(FEET+1)-1:0]   i_idx,
    output lgps_pkg::t_sts              o_sts,
    input  logic [3:0]                  i_requested_gait,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [1:0]                  o_foot_index,
    output logic                        o_in_contact,
    output logic                        o_touchdown_edge,
    output logic                        o_liftoff_edge,
    output logic [23:0]                 o_foot_phase_out,
    output logic [16:0]                 o_stance_subphase,
    output logic [16:0]                 o_swing_subphase,
    output logic [26:0]                 o_stance_left,
    output logic [26:0]                 o_swing_left,
    output logic [2:0]                  o_stance_count,
    output logic [3:0]                  o_active_gait,
    output logic                        o_last_foot
);
    import lgps_pkg::*;

    localparam int IW = $clog2(FEET + 1);
    localparam int FW = $clog2(FEET);

    logic [3:0]  r_req, r_gait, n_gait;
    logic [26:0] r_per, n_per, r_nper, n_nper, r_newp;
    logic [24:0] r_sw, n_sw, r_nsw, n_nsw, r_trsw, n_trsw;
    logic [23:0] r_ref, n_ref, r_dph, n_dph;
    logic        r_ovr, n_ovr, r_built, n_built;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_en [FEET];
    logic        n_en [FEET];
    logic [23:0] r_off [FEET];
    logic [23:0] n_off [FEET];
    logic [23:0] r_fph [FEET];
    logic [23:0] n_fph [FEET];
    logic [24:0] r_fsw [FEET];
    logic [24:0] n_fsw [FEET];
    logic [26:0] r_fper [FEET];
    logic [26:0] n_fper [FEET];
    logic        r_cont [FEET];
    logic        n_cont [FEET];
    logic        r_td [FEET];
    logic        n_td [FEET];
    logic        r_lo [FEET];
    logic        n_lo [FEET];

    logic [51:0] r_prod;
    logic [23:0] r_ph, r_fnum;
    logic [24:0] r_fden;
    logic        r_st, r_fsk;
    logic        r_ov;

    logic [FW-1:0] fi;
    logic          tr_last;
    logic [3:0]    code;
    logic          build_needed;
    t_preset       pre;
    logic [24:0]   sw_ov;
    logic          ovr_hit;
    logic [28:0]   per3;
    logic [26:0]   newp;
    logic [26:0]   mul_a;
    logic [24:0]   mul_b, frac;
    logic [23:0]   ph;
    logic [24:0]   fsw;
    logic          st;
    logic [24:0]   term;
    logic [24:0]   shrink_res;
    logic [23:0]   dph_val;
    logic          div_done;
    logic [NUM_W-1:0] div_q, div_num;
    logic [DEN_W-1:0] div_den;
    logic [CNT_W-1:0] div_bits;

    assign fi = i_idx[FW-1:0];
    assign tr_last = i_idx == IW'(FEET);

    always_comb begin
        code = r_req;
        build_needed = 1'b0;
        case (i_cfg.mode) inside
            MODE_FOLLOW, MODE_FOLLOW_ALT, MODE_NATURAL: begin
                code = r_req;
                build_needed = r_gait != r_req;
            end
            MODE_CHOICE, MODE_OVERRIDE: begin
                code = i_cfg.choice;
                build_needed = r_gait != i_cfg.choice;
            end
            default: ;
        endcase
    end

    assign pre = lgps_preset(code);
    assign sw_ov = (i_cfg.switching > ONE24) ? ONE24 : i_cfg.switching;

    always_comb begin
        logic [26:0] dp;
        logic [24:0] ds;
        dp = (r_per > i_cfg.period) ? r_per - i_cfg.period : i_cfg.period - r_per;
        ds = (r_sw > sw_ov) ? r_sw - sw_ov : sw_ov - r_sw;
        ovr_hit = r_ovr && (dp >= PERIOD_TOL || ds >= SWITCH_TOL);
    end

    assign per3 = {2'b0, r_per} + {1'b0, r_per, 1'b0};
    assign newp = (per3 > {2'b0, MASK27}) ? MASK27 : per3[26:0];

    assign ph = r_fph[fi] + r_dph;
    assign fsw = r_fsw[fi];
    assign st = {1'b0, ph} <= fsw;
    assign frac = tr_last ? r_sw : {1'b0, r_fph[fi]};

    always_comb begin
        if (i_cmd.tr_mul) begin
            mul_a = r_per;
            mul_b = ONE24 - frac;
        end else begin
            mul_a = r_fper[fi];
            mul_b = st ? fsw - {1'b0, ph} : ONE24 - {1'b0, ph};
        end
    end

    assign term = (r_newp == 27'd0) ? 25'd0 :
                  (div_q > NUM_W'(ONE24)) ? ONE24 : div_q[24:0];
    assign shrink_res = ONE24 - term;
    assign dph_val = o_sts.dph_skip ? 24'd0 : div_q[23:0];

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_TR: begin
                div_num = r_prod;
                div_den = r_newp;
                div_bits = N_TR;
            end
            DIV_DPH: begin
                div_num = {i_cfg.tick, 31'd0};
                div_den = r_per;
                div_bits = N_DPH;
            end
            default: begin
                div_num = {r_fnum, 28'd0};
                div_den = {2'b0, r_fden};
                div_bits = N_FOOT;
            end
        endcase
    end

    lgps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_bits  (div_bits),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        logic refresh;
        refresh = 1'b0;
        n_gait = r_gait;
        n_per = r_per;
        n_sw = r_sw;
        n_ref = r_ref;
        n_nper = r_nper;
        n_nsw = r_nsw;
        n_ovr = r_ovr;
        n_built = r_built;
        n_trsw = r_trsw;
        n_dph = r_dph;
        n_cnt = r_cnt;
        n_en = r_en;
        n_off = r_off;
        n_fph = r_fph;
        n_fsw = r_fsw;
        n_fper = r_fper;
        n_cont = r_cont;
        n_td = r_td;
        n_lo = r_lo;

        if (i_cmd.mode_step) begin
            n_built = build_needed;
            if (build_needed) begin
                if (code != GAIT_CUSTOM) begin
                    n_per = pre.period;
                    n_ref = pre.init;
                    n_sw = pre.sw;
                    n_ovr = pre.ovr;
                    for (int f = 0; f < FEET; f++) begin
                        n_en[f] = pre.en[f];
                        n_off[f] = pre.off[f];
                    end
                end
                n_gait = code;
                refresh = 1'b1;
            end
        end

        if (i_cmd.tr_store) begin
            if (tr_last) begin
                n_trsw = shrink_res;
            end else begin
                n_off[fi] = shrink_res[23:0];
            end
        end

        if (i_cmd.tr_end) begin
            n_sw = r_trsw;
            n_per = r_newp;
            n_ref = 24'd0;
            n_ovr = 1'b0;
            n_built = 1'b1;
            n_gait = GAIT_TRANSITION;
            for (int f = 0; f < FEET; f++) begin
                n_en[f] = 1'b1;
            end
            refresh = 1'b1;
        end

        if (i_cmd.post) begin
            if (i_cfg.mode == MODE_OVERRIDE && ovr_hit) begin
                n_per = i_cfg.period;
                n_sw = sw_ov;
                refresh = 1'b1;
            end else if (i_cfg.mode == MODE_NATURAL) begin
                if (r_built) begin
                    n_nper = r_per;
                    n_nsw = r_sw;
                end else begin
                    n_per = r_nper;
                    n_sw = r_nsw;
                    refresh = 1'b1;
                end
            end
        end

        if (refresh) begin
            for (int f = 0; f < FEET; f++) begin
                if (n_en[f]) begin
                    n_fper[f] = n_per;
                    n_fsw[f] = n_sw;
                    n_fph[f] = n_ref + n_off[f];
                end else begin
                    n_fper[f] = DISABLED_PERIOD;
                    n_fsw[f] = 25'd0;
                    n_fph[f] = 24'd0;
                end
            end
        end

        if (i_cmd.dph_store) begin
            n_dph = dph_val;
            n_ref = r_ref + dph_val;
            n_cnt = 3'd0;
        end

        if (i_cmd.foot_store) begin
            if (r_en[fi]) begin
                n_fph[fi] = r_ph;
                n_cont[fi] = r_st;
                if (r_st) begin
                    n_td[fi] = !r_cont[fi];
                    n_cnt = r_cnt + 3'd1;
                end else begin
                    n_lo[fi] = r_cont[fi];
                end
            end else begin
                n_fph[fi] = r_fsw[fi][23:0];
                n_cont[fi] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gait <= GAIT_STAND;
            r_per <= STAND_PERIOD;
            r_sw <= ONE24;
            r_ref <= 24'd0;
            r_nper <= STAND_PERIOD;
            r_nsw <= ONE24;
            r_ovr <= 1'b0;
            r_built <= 1'b0;
            r_dph <= 24'd0;
            r_cnt <= 3'd0;
            r_ov <= 1'b0;
            for (int f = 0; f < FEET; f++) begin
                r_en[f] <= 1'b1;
                r_off[f] <= HALF24;
                r_fph[f] <= HALF24;
                r_fsw[f] <= ONE24;
                r_fper[f] <= STAND_PERIOD;
                r_cont[f] <= 1'b0;
                r_td[f] <= 1'b0;
                r_lo[f] <= 1'b0;
            end
        end else begin
            r_gait <= n_gait;
            r_per <= n_per;
            r_sw <= n_sw;
            r_ref <= n_ref;
            r_nper <= n_nper;
            r_nsw <= n_nsw;
            r_ovr <= n_ovr;
            r_built <= n_built;
            r_dph <= n_dph;
            r_cnt <= n_cnt;
            r_en <= n_en;
            r_off <= n_off;
            r_fph <= n_fph;
            r_fsw <= n_fsw;
            r_fper <= n_fper;
            r_cont <= n_cont;
            r_td <= n_td;
            r_lo <= n_lo;
            if (i_cmd.foot_store) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_trsw <= n_trsw;
        if (i_cmd.load_req) begin
            r_req <= i_requested_gait;
        end
        if (i_cmd.tr_mul) begin
            r_newp <= newp;
        end
        if (i_cmd.tr_mul || i_cmd.foot_prep) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.foot_prep) begin
            r_ph <= ph;
            r_st <= st;
            r_fnum <= st ? ph : ph - fsw[23:0];
            r_fden <= st ? fsw : ONE24 - fsw;
            r_fsk <= !r_en[fi] || (st && fsw == 25'd0);
        end
        if (i_cmd.foot_store) begin
            o_foot_index <= 2'(i_idx);
            o_in_contact <= n_cont[fi];
            o_touchdown_edge <= n_td[fi];
            o_liftoff_edge <= n_lo[fi];
            o_foot_phase_out <= n_fph[fi];
            o_stance_subphase <= !r_en[fi] ? 17'd0 :
                                 (!r_st || r_fsk) ? SUB_ONE : div_q[16:0];
            o_swing_subphase <= (r_en[fi] && !r_st) ? div_q[16:0] : 17'd0;
            o_stance_left <= (r_en[fi] && r_st) ? r_prod[50:24] : 27'd0;
            o_swing_left <= (r_en[fi] && !r_st) ? r_prod[50:24] : 27'd0;
            o_stance_count <= n_cnt;
            o_active_gait <= r_gait;
            o_last_foot <= i_idx == IW'(FEET - 1);
        end
    end

    assign o_valid = r_ov;

    assign o_sts.tr_needed = build_needed && code == GAIT_TRANSITION;
    assign o_sts.tr_skip = r_newp == 27'd0;
    assign o_sts.dph_skip = r_gait == GAIT_STAND || r_per == 27'd0;
    assign o_sts.foot_skip = r_fsk;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_ov || !i_stall;

endmodule

// ===== hw/rtl/lgps_ctrl.sv =====
// Tick sequencer: mode handling, transition rebuild, phase step, per-foot results.
// Depends on lgps_pkg for the state, command and status types.
module lgps_ctrl #(
    parameter int FEET = lgps_pkg::FEET_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  lgps_pkg::t_sts              i_sts,
    output lgps_pkg::t_cmd              o_cmd,
    output logic [$clog2(FEET+1)-1:0]   o_idx
);
    import lgps_pkg::*;

    localparam int IW = $clog2(FEET + 1);

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic tr_last, foot_last;

    assign tr_last = r_idx == IW'(FEET);
    assign foot_last = r_idx == IW'(FEET - 1);
    assign o_idx = r_idx;
    assign o_stall = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_valid) n_state = S_MODE;
            S_MODE:      n_state = i_sts.tr_needed ? S_TR_MUL : S_POST;
            S_TR_MUL:    n_state = S_TR_DIV;
            S_TR_DIV: begin
                if (i_sts.tr_skip) begin
                    n_state = tr_last ? S_TR_END : S_TR_MUL;
                end else begin
                    n_state = S_TR_WAIT;
                end
            end
            S_TR_WAIT:   if (i_sts.div_done) n_state = tr_last ? S_TR_END : S_TR_MUL;
            S_TR_END:    n_state = S_POST;
            S_POST:      n_state = S_DPH;
            S_DPH:       n_state = i_sts.dph_skip ? S_FOOT_MUL : S_DPH_WAIT;
            S_DPH_WAIT:  if (i_sts.div_done) n_state = S_FOOT_MUL;
            S_FOOT_MUL:  n_state = S_FOOT_DIV;
            S_FOOT_DIV:  n_state = i_sts.foot_skip ? S_FOOT_OUT : S_FOOT_WAIT;
            S_FOOT_WAIT: if (i_sts.div_done) n_state = S_FOOT_OUT;
            S_FOOT_OUT:  if (i_sts.out_free) n_state = foot_last ? S_IDLE : S_FOOT_MUL;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        unique case (r_state) inside
            S_MODE, S_POST: n_idx = '0;
            S_TR_DIV:   if (i_sts.tr_skip && !tr_last) n_idx = r_idx + 1'b1;
            S_TR_WAIT:  if (i_sts.div_done && !tr_last) n_idx = r_idx + 1'b1;
            S_FOOT_OUT: if (i_sts.out_free && !foot_last) n_idx = r_idx + 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.div_sel = DIV_FOOT;
        unique case (r_state)
            S_IDLE:      o_cmd.load_req = i_valid;
            S_MODE:      o_cmd.mode_step = !i_sts.tr_needed;
            S_TR_MUL:    o_cmd.tr_mul = 1'b1;
            S_TR_DIV: begin
                o_cmd.div_sel = DIV_TR;
                o_cmd.tr_store = i_sts.tr_skip;
                o_cmd.div_start = !i_sts.tr_skip;
            end
            S_TR_WAIT: begin
                o_cmd.div_sel = DIV_TR;
                o_cmd.tr_store = i_sts.div_done;
            end
            S_TR_END:    o_cmd.tr_end = 1'b1;
            S_POST:      o_cmd.post = 1'b1;
            S_DPH: begin
                o_cmd.div_sel = DIV_DPH;
                o_cmd.dph_store = i_sts.dph_skip;
                o_cmd.div_start = !i_sts.dph_skip;
            end
            S_DPH_WAIT: begin
                o_cmd.div_sel = DIV_DPH;
                o_cmd.dph_store = i_sts.div_done;
            end
            S_FOOT_MUL:  o_cmd.foot_prep = 1'b1;
            S_FOOT_DIV:  o_cmd.div_start = !i_sts.foot_skip;
            S_FOOT_WAIT: ;
            S_FOOT_OUT:  o_cmd.foot_store = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/legged_gait_phase_scheduler.sv =====
// Periodic gait contact-phase scheduler for a legged robot, top level.
// Depends on lgps_pkg, lgps_regs, lgps_ctrl and lgps_datapath.
//
// Usage: one input transfer (i_requested_gait) is one control tick. The block
// answers with FEET result transfers, one per foot in foot order; the last one
// carries o_last_foot. Configuration is written over the APB-style port while
// no tick is in flight.
// A new tick is taken only when the sequencer is back in idle, after the last
// result of the current tick has been stored in the output register. The stand
// gait skips the phase step division. A change to the transition-to-stand gait
// adds a rebuild step per foot and one for the switching point, each with a
// division unless the new period is zero. The shared divider produces one
// quotient bit per cycle for the phase step and for each foot's subphase.
// Reset: synchronous, active low; the block starts in the stand gait with all
// feet enabled and the configuration registers at their reset values.
// Stall: a result waits in the output register while i_stall is high; the
// sequencer holds on the next foot until the register is free, and o_stall
// stays high until the tick is done.
module legged_gait_phase_scheduler #(
    parameter int FEET = lgps_pkg::FEET_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [3:0]   i_requested_gait,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [1:0]   o_foot_index,
    output logic         o_in_contact,
    output logic         o_touchdown_edge,
    output logic         o_liftoff_edge,
    output logic [23:0]  o_foot_phase_out,
    output logic [16:0]  o_stance_subphase,
    output logic [16:0]  o_swing_subphase,
    output logic [26:0]  o_stance_left,
    output logic [26:0]  o_swing_left,
    output logic [2:0]   o_stance_count,
    output logic [3:0]   o_active_gait,
    output logic         o_last_foot
);
    import lgps_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    logic [$clog2(FEET+1)-1:0] idx;

    lgps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lgps_ctrl #(.FEET(FEET)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_idx   (idx)
    );

    lgps_datapath #(.FEET(FEET)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .i_idx             (idx),
        .o_sts             (sts),
        .i_requested_gait  (i_requested_gait),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_foot_index      (o_foot_index),
        .o_in_contact      (o_in_contact),
        .o_touchdown_edge  (o_touchdown_edge),
        .o_liftoff_edge    (o_liftoff_edge),
        .o_foot_phase_out  (o_foot_phase_out),
        .o_stance_subphase (o_stance_subphase),
        .o_swing_subphase  (o_swing_subphase),
        .o_stance_left     (o_stance_left),
        .o_swing_left      (o_swing_left),
        .o_stance_count    (o_stance_count),
        .o_active_gait     (o_active_gait),
        .o_last_foot       (o_last_foot)
    );

endmodule
